// ===== rtl/core/xy_stepper_move_controller_assert.svh =====
// ----------------------------------------------------------------------------
// xy_stepper_move_controller_assert.svh
// Assertion macros used by the stepper controller port checker.
// ----------------------------------------------------------------------------
`ifndef XY_STEPPER_MOVE_CONTROLLER_ASSERT_SVH
`define XY_STEPPER_MOVE_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on aclk, quiet during reset
`define XYSM_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xysm assertion failed");

// next-cycle implication
`define XYSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("xysm assertion failed");

`endif

// ===== rtl/core/xysm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xysm_pkg
// Types, constants and the stage microprogram of the XY stepper controller.
// ----------------------------------------------------------------------------
package xysm_pkg;

    localparam int POS_WIDTH_DEF  = 16;
    localparam int PHASES_DEF     = 4;
    localparam int TGT_W          = 16;
    localparam int COIL_W         = 8;
    localparam int WORD_W         = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 48;
    localparam int S_TUSER_W      = 2;
    localparam int STAGE_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_PHASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_PHASE = 2'd1;

    typedef enum logic [1:0] {
        CMD_IDLE = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_HOME = 2'd2,
        CMD_MAX  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_RUN  = 2'd1,
        SEQ_EMIT = 2'd2
    } seq_state_t;

    typedef struct packed {
        dir_t dx;
        dir_t dy;
        logic last;
    } ucode_t;

    typedef struct packed {
        logic right;
        logic left;
        logic up;
        logic down;
    } limits_t;

    typedef struct packed {
        logic step;
        dir_t dir;
        logic zero;
        logic load_goal;
    } axis_ctl_t;

    typedef struct packed {
        logic short_pos;
        logic short_neg;
        logic at_goal;
    } axis_stat_t;

    localparam ucode_t MOVE_PROG [8] = '{
        '{DIR_POS,  DIR_POS,  1'b0},
        '{DIR_POS,  DIR_NEG,  1'b0},
        '{DIR_NEG,  DIR_NEG,  1'b0},
        '{DIR_NEG,  DIR_POS,  1'b0},
        '{DIR_NONE, DIR_NEG,  1'b0},
        '{DIR_NONE, DIR_POS,  1'b0},
        '{DIR_NEG,  DIR_NONE, 1'b0},
        '{DIR_POS,  DIR_NONE, 1'b1}
    };

    localparam ucode_t HOME_PROG [4] = '{
        '{DIR_NEG,  DIR_NEG,  1'b0},
        '{DIR_NONE, DIR_NEG,  1'b0},
        '{DIR_NEG,  DIR_NONE, 1'b1},
        '{DIR_NONE, DIR_NONE, 1'b1}
    };

    localparam ucode_t MAX_PROG [4] = '{
        '{DIR_POS,  DIR_POS,  1'b0},
        '{DIR_NONE, DIR_POS,  1'b0},
        '{DIR_POS,  DIR_NONE, 1'b1},
        '{DIR_NONE, DIR_NONE, 1'b1}
    };

    localparam ucode_t IDLE_WORD = '{DIR_NONE, DIR_NONE, 1'b1};

    function automatic ucode_t seq_rom(input cmd_t kind, input logic [STAGE_W-1:0] stage);
        ucode_t w;
        case (kind)
            CMD_MOVE: w = MOVE_PROG[stage];
            CMD_HOME: w = HOME_PROG[stage[1:0]];
            CMD_MAX:  w = MAX_PROG[stage[1:0]];
            default:  w = IDLE_WORD;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/xysm_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xysm_axis
// One motor axis: saturating position, goal, coil phase index and pattern.
// ----------------------------------------------------------------------------
module xysm_axis #(
    parameter int PHASES_PER_AXIS = xysm_pkg::PHASES_DEF,
    parameter int POS_WIDTH       = xysm_pkg::POS_WIDTH_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire xysm_pkg::axis_ctl_t              ctl,
    input  wire logic signed [xysm_pkg::TGT_W-1:0] target,
    input  wire logic [xysm_pkg::WORD_W-1:0]      phase_word,
    output xysm_pkg::axis_stat_t                  stat,
    output logic signed [POS_WIDTH-1:0]           pos,
    output logic [xysm_pkg::COIL_W-1:0]           pattern
);

    localparam int PH_W = (PHASES_PER_AXIS > 1) ? $clog2(PHASES_PER_AXIS) : 1;
    localparam logic signed [32:0] PMAX = (33'sd1 <<< (POS_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] PMIN = -PMAX - 33'sd1;
    localparam logic signed [POS_WIDTH-1:0] POS_TOP = POS_WIDTH'(PMAX);
    localparam logic signed [POS_WIDTH-1:0] POS_BOT = POS_WIDTH'(PMIN);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASES_PER_AXIS - 1);

    logic signed [POS_WIDTH-1:0] pos_reg, pos_next;
    logic signed [POS_WIDTH-1:0] goal_reg, goal_next;
    logic [PH_W-1:0]             idx_reg, idx_next;
    logic signed [32:0]          tgt_wide;
    logic [3:0]                  idx_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            goal_reg <= '0;
            idx_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            goal_reg <= goal_next;
            idx_reg  <= idx_next;
        end
    end

    always_comb begin
        tgt_wide  = 33'(target);
        goal_next = goal_reg;
        if (ctl.load_goal) begin
            if (tgt_wide > PMAX) begin
                goal_next = POS_TOP;
            end else if (tgt_wide < PMIN) begin
                goal_next = POS_BOT;
            end else begin
                goal_next = POS_WIDTH'(tgt_wide);
            end
        end

        pos_next = pos_reg;
        idx_next = idx_reg;
        if (ctl.zero) begin
            pos_next = '0;
        end else if (ctl.step) begin
            if (ctl.dir == xysm_pkg::DIR_POS) begin
                idx_next = (idx_reg == '0) ? PH_LAST : idx_reg - PH_W'(1);
                if (pos_reg != POS_TOP) pos_next = pos_reg + POS_WIDTH'(1);
            end else if (ctl.dir == xysm_pkg::DIR_NEG) begin
                idx_next = (idx_reg == PH_LAST) ? '0 : idx_reg + PH_W'(1);
                if (pos_reg != POS_BOT) pos_next = pos_reg - POS_WIDTH'(1);
            end
        end
    end

    // pattern at the index after this cycle's update
    always_comb begin
        idx_ext = 4'(idx_next);
        if (idx_ext < 4'd4) begin
            pattern = phase_word[{idx_ext[1:0], 3'b000} +: xysm_pkg::COIL_W];
        end else begin
            pattern = '0;
        end
    end

    assign pos            = pos_reg;
    assign stat.short_pos = pos_reg < goal_reg;
    assign stat.short_neg = pos_reg > goal_reg;
    assign stat.at_goal   = pos_reg == goal_reg;

endmodule
`default_nettype wire

// ===== rtl/core/xy_stepper_move_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xy_stepper_move_controller
// Two-axis stepper positioner driven by a stage microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per step tick. s_tuser carries the command
//   (tick only, move, home, find maximum), s_tdata the move target and the
//   four end-stop switches. m_ channel: one result per tick with the coil
//   drive, position and busy/done/status flags.
//   cfg channel: writes the x and y coil phase words (index 0 and 1), taken
//   every cycle; other indexes are dropped. Write only while idle.
//   Sequencing: a tick walks the stage table one entry per cycle until a
//   stage can step or the program ends (a plain tick with no command
//   running skips the walk); the EMIT state then loads the output register
//   once no held result is waiting. A new tick is accepted only in the idle
//   state, after the previous result has been loaded.
//   A held result sits in the output register; s_tready is high again as
//   soon as the result is loaded, and a second result waits in the
//   sequencer until the first is taken.
//   Reset (aresetn low, synchronous) clears position, goal, phase indexes,
//   phase words and the running command.
// ----------------------------------------------------------------------------
module xy_stepper_move_controller #(
    parameter int PHASES_PER_AXIS = xysm_pkg::PHASES_DEF,
    parameter int POS_WIDTH       = xysm_pkg::POS_WIDTH_DEF
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    // cfg write channel
    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [xysm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [xysm_pkg::WORD_W-1:0]         cfg_data,
    // tick requests
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // target_x[15:0], target_y[31:16], limit_down[32], limit_up[33],
    // limit_left[34], limit_right[35], zero pad[39:36]
    input  wire logic [xysm_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  wire logic [xysm_pkg::S_TUSER_W-1:0]      s_tuser,
    // results
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // coil_drive[7:0], position_x[23:8], position_y[39:24], stepped[40],
    // busy_res[41], done_res[42], status[43], zero pad[47:44]
    output logic [xysm_pkg::M_TDATA_W-1:0]           m_tdata
);

    xysm_pkg::seq_state_t        state_reg, state_next;
    xysm_pkg::cmd_t              kind_reg, kind_next;
    logic [xysm_pkg::STAGE_W-1:0] stage_reg, stage_next;
    xysm_pkg::limits_t           lim_reg, lim_next;
    logic                        stepped_reg, stepped_next;
    logic                        done_reg, done_next;
    logic                        status_reg, status_next;
    logic                        m_valid_reg, m_valid_next;
    logic [xysm_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [xysm_pkg::WORD_W-1:0] xw_reg, xw_next;
    logic [xysm_pkg::WORD_W-1:0] yw_reg, yw_next;

    xysm_pkg::axis_ctl_t         x_ctl, y_ctl;
    xysm_pkg::axis_stat_t        x_stat, y_stat;
    logic signed [POS_WIDTH-1:0] x_pos, y_pos;
    logic [xysm_pkg::COIL_W-1:0] x_pat, y_pat;
    xysm_pkg::ucode_t            uw;
    logic                        x_ok, y_ok, is_move, accept;
    logic signed [xysm_pkg::TGT_W-1:0] tgt_x, tgt_y;

    assign tgt_x = s_tdata[15:0];
    assign tgt_y = s_tdata[31:16];

    xysm_axis #(
        .PHASES_PER_AXIS (PHASES_PER_AXIS),
        .POS_WIDTH       (POS_WIDTH)
    ) u_axis_x (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (x_ctl),
        .target     (tgt_x),
        .phase_word (xw_reg),
        .stat       (x_stat),
        .pos        (x_pos),
        .pattern    (x_pat)
    );

    xysm_axis #(
        .PHASES_PER_AXIS (PHASES_PER_AXIS),
        .POS_WIDTH       (POS_WIDTH)
    ) u_axis_y (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (y_ctl),
        .target     (tgt_y),
        .phase_word (yw_reg),
        .stat       (y_stat),
        .pos        (y_pos),
        .pattern    (y_pat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= xysm_pkg::SEQ_IDLE;
            kind_reg    <= xysm_pkg::CMD_IDLE;
            stage_reg   <= '0;
            m_valid_reg <= 1'b0;
            xw_reg      <= '0;
            yw_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            stage_reg   <= stage_next;
            m_valid_reg <= m_valid_next;
            xw_reg      <= xw_next;
            yw_reg      <= yw_next;
        end
        lim_reg     <= lim_next;
        stepped_reg <= stepped_next;
        done_reg    <= done_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    // config writes
    assign cfg_ready = 1'b1;
    always_comb begin
        xw_next = xw_reg;
        yw_next = yw_reg;
        if (cfg_valid) begin
            case (cfg_index)
                xysm_pkg::REG_X_PHASE: xw_next = cfg_data;
                xysm_pkg::REG_Y_PHASE: yw_next = cfg_data;
                default: ;
            endcase
        end
    end

    // stage condition from the current control word
    always_comb begin
        uw      = xysm_pkg::seq_rom(kind_reg, stage_reg);
        is_move = kind_reg == xysm_pkg::CMD_MOVE;
        case (uw.dx)
            xysm_pkg::DIR_POS: x_ok = !lim_reg.right && (!is_move || x_stat.short_pos);
            xysm_pkg::DIR_NEG: x_ok = !lim_reg.left && (!is_move || x_stat.short_neg);
            default:           x_ok = 1'b1;
        endcase
        case (uw.dy)
            xysm_pkg::DIR_POS: y_ok = !lim_reg.up && (!is_move || y_stat.short_pos);
            xysm_pkg::DIR_NEG: y_ok = !lim_reg.down && (!is_move || y_stat.short_neg);
            default:           y_ok = 1'b1;
        endcase
    end

    assign s_tready = state_reg == xysm_pkg::SEQ_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        stage_next   = stage_reg;
        lim_next     = lim_reg;
        stepped_next = stepped_reg;
        done_next    = done_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        x_ctl        = '{step: 1'b0, dir: uw.dx, zero: 1'b0, load_goal: 1'b0};
        y_ctl        = '{step: 1'b0, dir: uw.dy, zero: 1'b0, load_goal: 1'b0};

        case (state_reg)
            xysm_pkg::SEQ_IDLE: begin
                if (accept) begin
                    lim_next     = s_tdata[35:32];
                    stepped_next = 1'b0;
                    done_next    = 1'b0;
                    status_next  = 1'b0;
                    if (xysm_pkg::cmd_t'(s_tuser) != xysm_pkg::CMD_IDLE) begin
                        kind_next  = xysm_pkg::cmd_t'(s_tuser);
                        stage_next = '0;
                    end
                    if (xysm_pkg::cmd_t'(s_tuser) == xysm_pkg::CMD_MOVE) begin
                        x_ctl.load_goal = 1'b1;
                        y_ctl.load_goal = 1'b1;
                    end
                    state_next = xysm_pkg::SEQ_RUN;
                end
            end
            xysm_pkg::SEQ_RUN: begin
                if (kind_reg == xysm_pkg::CMD_IDLE) begin
                    state_next = xysm_pkg::SEQ_EMIT;
                end else if (x_ok && y_ok) begin
                    x_ctl.step   = uw.dx != xysm_pkg::DIR_NONE;
                    y_ctl.step   = uw.dy != xysm_pkg::DIR_NONE;
                    stepped_next = 1'b1;
                    state_next   = xysm_pkg::SEQ_EMIT;
                end else if (uw.last) begin
                    done_next = 1'b1;
                    if (is_move) begin
                        status_next = !(x_stat.at_goal && y_stat.at_goal);
                    end
                    if (kind_reg == xysm_pkg::CMD_HOME) begin
                        x_ctl.zero = 1'b1;
                        y_ctl.zero = 1'b1;
                    end
                    kind_next  = xysm_pkg::CMD_IDLE;
                    stage_next = '0;
                    state_next = xysm_pkg::SEQ_EMIT;
                end else begin
                    stage_next = stage_reg + 3'd1;
                end
            end
            xysm_pkg::SEQ_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, status_reg, done_reg,
                                    kind_reg != xysm_pkg::CMD_IDLE, stepped_reg,
                                    16'(y_pos), 16'(x_pos), x_pat + y_pat};
                    state_next   = xysm_pkg::SEQ_IDLE;
                end
            end
            default: begin
                state_next = xysm_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/xysm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xysm_checker
// Port-level checks on the result channel of the XY stepper controller.
// ----------------------------------------------------------------------------
`include "xy_stepper_move_controller_assert.svh"

module xysm_checker (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 m_tvalid,
    input wire                                 m_tready,
    input wire logic [xysm_pkg::M_TDATA_W-1:0] m_tdata
);

    // stop-short status only ever comes with done
    `XYSM_ASSERT(a_status_needs_done, m_tvalid && m_tdata[43], m_tdata[42])
    // a finishing tick takes no step
    `XYSM_ASSERT(a_done_no_step, m_tvalid && m_tdata[42], !m_tdata[40])
    // a finished command is no longer running
    `XYSM_ASSERT(a_done_not_busy, m_tvalid && m_tdata[42], !m_tdata[41])
    // stalled result holds
    `XYSM_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind xy_stepper_move_controller xysm_checker u_xysm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/xy_stepper_move_controller_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xy_stepper_move_controller_checker
// Watches the config, tick and result channels of the stepper controller.
// It keeps its own copy of the positioner state, predicts the result of
// every accepted tick request and compares each result with the oldest one.
// ----------------------------------------------------------------------------
module xy_stepper_move_controller_checker
    import xysm_pkg::*;
(
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    input  wire                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [WORD_W-1:0]       cfg_data,
    input  wire                          s_tvalid,
    input  wire                          s_tready,
    input  wire logic [S_TDATA_W-1:0]    s_tdata,
    input  wire logic [S_TUSER_W-1:0]    s_tuser,
    input  wire                          m_tvalid,
    input  wire                          m_tready,
    input  wire logic [M_TDATA_W-1:0]    m_tdata,
    output int                           fault_count,
    output int                           backlog
);

    localparam int POS_HI = (1 << (POS_WIDTH_DEF - 1)) - 1;
    localparam int POS_LO = -POS_HI - 1;

    typedef struct packed {
        logic [3:0]        pad;
        logic              status;
        logic              done;
        logic              busy;
        logic              stepped;
        logic [TGT_W-1:0]  pos_y;
        logic [TGT_W-1:0]  pos_x;
        logic [COIL_W-1:0] coil;
    } tick_result_t;

    logic [WORD_W-1:0] x_words, y_words;
    int                x_phase, y_phase;
    int                pos_x, pos_y, goal_x, goal_y;
    int                stage_no;
    cmd_t              active_cmd;
    int                ticks_checked;
    tick_result_t      predicted_ticks[$];

    function automatic int saturate(int v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    function automatic logic [COIL_W-1:0] coil_pattern(logic [WORD_W-1:0] w, int idx);
        return (idx >= 4) ? '0 : w[8*idx +: 8];
    endfunction

    function automatic int phase_on(int i);
        return (i + 1 >= PHASES_DEF) ? 0 : i + 1;
    endfunction

    function automatic int phase_off(int i);
        return (i == 0) ? PHASES_DEF - 1 : i - 1;
    endfunction

    function automatic int stage_total(cmd_t k);
        case (k)
            CMD_MOVE:          return 8;
            CMD_HOME, CMD_MAX: return 3;
            default:           return 0;
        endcase
    endfunction

    // unit direction of each stage, +1 is up/right
    function automatic void stage_heading(cmd_t k, int s, output int dx, output int dy);
        dx = 0;
        dy = 0;
        case (k)
            CMD_MOVE: begin
                case (s)
                    0: begin dx = 1;  dy = 1;  end
                    1: begin dx = 1;  dy = -1; end
                    2: begin dx = -1; dy = -1; end
                    3: begin dx = -1; dy = 1;  end
                    4: dy = -1;
                    5: dy = 1;
                    6: dx = -1;
                    default: dx = 1;
                endcase
            end
            CMD_HOME: begin
                case (s)
                    0: begin dx = -1; dy = -1; end
                    1: dy = -1;
                    default: dx = -1;
                endcase
            end
            CMD_MAX: begin
                case (s)
                    0: begin dx = 1; dy = 1; end
                    1: dy = 1;
                    default: dx = 1;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic bit stage_open(int dx, int dy, limits_t lim);
        if (dy < 0 && lim.down)  return 1'b0;
        if (dy > 0 && lim.up)    return 1'b0;
        if (dx < 0 && lim.left)  return 1'b0;
        if (dx > 0 && lim.right) return 1'b0;
        if (active_cmd == CMD_MOVE) begin
            if (dx > 0 && pos_x >= goal_x) return 1'b0;
            if (dx < 0 && pos_x <= goal_x) return 1'b0;
            if (dy > 0 && pos_y >= goal_y) return 1'b0;
            if (dy < 0 && pos_y <= goal_y) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic tick_result_t step_positioner(cmd_t mode, logic [TGT_W-1:0] tx,
                                                     logic [TGT_W-1:0] ty, limits_t lim);
        tick_result_t r;
        int           dx, dy;
        bit           moved;
        r     = '0;
        moved = 1'b0;
        if (mode != CMD_IDLE) begin
            active_cmd = mode;
            stage_no   = 0;
            if (mode == CMD_MOVE) begin
                goal_x = saturate(int'($signed(tx)));
                goal_y = saturate(int'($signed(ty)));
            end
        end
        if (active_cmd != CMD_IDLE) begin
            while (!moved && stage_no < stage_total(active_cmd)) begin
                stage_heading(active_cmd, stage_no, dx, dy);
                if (stage_open(dx, dy, lim)) begin
                    if (dy < 0) begin
                        y_phase = phase_on(y_phase);
                        pos_y   = saturate(pos_y - 1);
                    end
                    if (dy > 0) begin
                        y_phase = phase_off(y_phase);
                        pos_y   = saturate(pos_y + 1);
                    end
                    if (dx < 0) begin
                        x_phase = phase_on(x_phase);
                        pos_x   = saturate(pos_x - 1);
                    end
                    if (dx > 0) begin
                        x_phase = phase_off(x_phase);
                        pos_x   = saturate(pos_x + 1);
                    end
                    moved = 1'b1;
                end else begin
                    stage_no++;
                end
            end
            if (!moved) begin
                r.done = 1'b1;
                if (active_cmd == CMD_MOVE) begin
                    r.status = (pos_x != goal_x) || (pos_y != goal_y);
                end else if (active_cmd == CMD_HOME) begin
                    pos_x = 0;
                    pos_y = 0;
                end
                active_cmd = CMD_IDLE;
                stage_no   = 0;
            end
        end
        r.coil    = coil_pattern(x_words, x_phase) + coil_pattern(y_words, y_phase);
        r.pos_x   = pos_x[TGT_W-1:0];
        r.pos_y   = pos_y[TGT_W-1:0];
        r.stepped = moved;
        r.busy    = (active_cmd != CMD_IDLE);
        return r;
    endfunction

    function automatic void report(string what, logic [31:0] want, logic [31:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("request %0d %s: expected %0h, actual %0h", ticks_checked, what, want, got);
    endfunction

    always @(posedge aclk) begin
        tick_result_t want, got;
        if (!aresetn) begin
            x_words    = '0;
            y_words    = '0;
            x_phase    = 0;
            y_phase    = 0;
            pos_x      = 0;
            pos_y      = 0;
            goal_x     = 0;
            goal_y     = 0;
            stage_no   = 0;
            active_cmd = CMD_IDLE;
            predicted_ticks.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_X_PHASE: x_words = cfg_data;
                    REG_Y_PHASE: y_words = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (predicted_ticks.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result %h with no request outstanding", got);
                end else begin
                    want = predicted_ticks.pop_front();
                    if (got.coil !== want.coil)
                        report("coil_drive", 32'(want.coil), 32'(got.coil));
                    if (got.pos_x !== want.pos_x)
                        report("position_x", 32'(want.pos_x), 32'(got.pos_x));
                    if (got.pos_y !== want.pos_y)
                        report("position_y", 32'(want.pos_y), 32'(got.pos_y));
                    if (got.stepped !== want.stepped)
                        report("stepped", 32'(want.stepped), 32'(got.stepped));
                    if (got.busy !== want.busy)
                        report("busy", 32'(want.busy), 32'(got.busy));
                    if (got.done !== want.done)
                        report("done", 32'(want.done), 32'(got.done));
                    if (got.status !== want.status)
                        report("status", 32'(want.status), 32'(got.status));
                    ticks_checked++;
                end
            end
            if (s_tvalid && s_tready)
                predicted_ticks.push_back(step_positioner(cmd_t'(s_tuser),
                    s_tdata[15:0], s_tdata[31:16], limits_t'(s_tdata[35:32])));
        end
        backlog = predicted_ticks.size();
    end

endmodule

// ===== tb/tb_xy_stepper_move_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xy_stepper_move_controller
// Stimulus and verdict for the XY stepper controller. Directed ticks cover
// moves, preemption, homing, find-maximum and target extremes; random command
// runs follow under several coil word settings, one of them free of idling.
// ----------------------------------------------------------------------------
module tb_xy_stepper_move_controller;
    import xysm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int      RANDOM_BLOCK = 330;
    // switch sets, bit order right left up down
    localparam limits_t OPEN      = limits_t'(4'b0000);
    localparam limits_t SHUT      = limits_t'(4'b1111);
    localparam limits_t UP_SHUT   = limits_t'(4'b0010);
    localparam limits_t DOWN_SHUT = limits_t'(4'b0001);
    localparam limits_t DOWN_LEFT = limits_t'(4'b0101);
    localparam limits_t UP_RIGHT  = limits_t'(4'b1010);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  idling    = 1'b1;
    int                    fault_count;
    int                    backlog;

    xy_stepper_move_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    xy_stepper_move_controller_checker tick_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fault_count (fault_count),
        .backlog     (backlog)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= !idling || ($urandom_range(99) >= 35);
    end

    // leaves tvalid high; drain() drops it
    task automatic tick(cmd_t mode, logic [TGT_W-1:0] tx, logic [TGT_W-1:0] ty, limits_t lim);
        while (idling && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, lim, ty, tx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (backlog != 0) @(negedge aclk);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_regs(logic [WORD_W-1:0] x_word, logic [WORD_W-1:0] y_word);
        cfg_put(REG_X_PHASE, x_word);
        cfg_put(REG_Y_PHASE, y_word);
        cfg_put(REG_SPARE_A, $urandom);
        cfg_put(REG_SPARE_B, $urandom);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic limits_t loose_switches();
        limits_t l;
        l.down  = ($urandom_range(99) < 8);
        l.up    = ($urandom_range(99) < 8);
        l.left  = ($urandom_range(99) < 8);
        l.right = ($urandom_range(99) < 8);
        return l;
    endfunction

    // mostly a command followed by a run of plain ticks, some noise
    task automatic random_block(int n);
        int               sent;
        int               roll;
        int               run;
        cmd_t             kind;
        logic [TGT_W-1:0] tx, ty;
        sent = 0;
        while (sent < n) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                tick(cmd_t'($urandom_range(3)), TGT_W'($urandom), TGT_W'($urandom),
                     limits_t'(4'($urandom)));
                sent++;
            end else begin
                kind = (roll < 60) ? CMD_MOVE : (roll < 80) ? CMD_HOME : CMD_MAX;
                if ($urandom_range(9) == 0) begin
                    tx = TGT_W'($urandom);
                    ty = TGT_W'($urandom);
                end else begin
                    tx = TGT_W'(int'($urandom_range(96)) - 48);
                    ty = TGT_W'(int'($urandom_range(96)) - 48);
                end
                tick(kind, tx, ty, loose_switches());
                run = $urandom_range(40);
                repeat (run) tick(CMD_IDLE, TGT_W'($urandom), TGT_W'($urandom),
                                  loose_switches());
                sent += run + 1;
            end
            if ($urandom_range(149) == 0) drain();
        end
        drain();
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        write_regs(32'h0804_0201, 32'h8040_2010);

        tick(CMD_IDLE, 16'h0000, 16'h0000, OPEN);
        tick(CMD_MOVE, 16'd3, -16'sd2, OPEN);
        repeat (4) tick(CMD_IDLE, 16'h0000, 16'h0000, OPEN);
        // stopped short by the up switch
        tick(CMD_MOVE, 16'd4, 16'd4, UP_SHUT);
        repeat (2) tick(CMD_IDLE, 16'hFFFF, 16'hFFFF, UP_SHUT);
        // preempted by homing, which ends once down and left are shut
        tick(CMD_MOVE, -16'sd20, 16'd0, OPEN);
        tick(CMD_HOME, 16'h0000, 16'h0000, OPEN);
        tick(CMD_IDLE, 16'h0000, 16'h0000, DOWN_SHUT);
        tick(CMD_IDLE, 16'h0000, 16'h0000, DOWN_LEFT);
        tick(CMD_MAX, 16'h0000, 16'h0000, UP_RIGHT);
        tick(CMD_MOVE, 16'h7FFF, 16'h8000, OPEN);
        tick(CMD_IDLE, 16'h0000, 16'h0000, OPEN);
        tick(CMD_MOVE, 16'h8000, 16'h7FFF, OPEN);
        tick(CMD_IDLE, 16'h0000, 16'h0000, OPEN);
        tick(CMD_HOME, 16'hFFFF, 16'hFFFF, SHUT);
        tick(CMD_IDLE, 16'h5555, 16'hAAAA, SHUT);
        tick(CMD_MAX, 16'h0000, 16'h0000, OPEN);
        tick(CMD_IDLE, 16'h0000, 16'h0000, UP_RIGHT);
        drain();

        write_regs(32'h0000_0000, 32'h0000_0000);
        random_block(RANDOM_BLOCK);
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        idling <= 1'b0;
        random_block(RANDOM_BLOCK);
        idling <= 1'b1;
        write_regs($urandom, $urandom);
        random_block(RANDOM_BLOCK);
        write_regs($urandom, $urandom);
        random_block(RANDOM_BLOCK);

        repeat (20) @(posedge aclk);
        if (fault_count == 0) begin
            $display("xy_stepper_move_controller verification clean");
        end else begin
            $display("xy_stepper_move_controller verification failed");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("xy_stepper_move_controller verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/xysm_pkg.sv
rtl/core/xysm_axis.sv
rtl/core/xy_stepper_move_controller.sv
rtl/core/xysm_checker.sv
tb/xy_stepper_move_controller_checker.sv
tb/tb_xy_stepper_move_controller.sv
